// ----- hw/rtl/sha1md_pkg.sv -----
// Shared types, constants and round functions of the SHA-1 digest core.
package sha1md_pkg;

	localparam int unsigned BLOCK_BITS = 512;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hc3d2e1f0;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] LAST_WORD_IDX = 3'd4;

	typedef struct packed {
		logic                  final_blk;
		logic [BLOCK_BITS-1:0] blk;
	} blk_item_t;

	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (rnd < 7'd40) begin
			f = b ^ c ^ d;
		end else if (rnd < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20) begin
			k = K0;
		end else if (rnd < 7'd40) begin
			k = K1;
		end else if (rnd < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

endpackage

// ----- hw/rtl/sha1md_front.sv -----
// Byte intake: packs message words into blocks and appends pad and length.
module sha1md_front import sha1md_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] byte_present
	input  logic       s_tlast,
	output logic       push,
	output blk_item_t  push_item,
	input  logic       q_full
);

	localparam logic [1:0] F_ACC  = 2'd0;
	localparam logic [1:0] F_PAD  = 2'd1;
	localparam logic [1:0] F_FILL = 2'd2;
	localparam logic [1:0] F_LEN  = 2'd3;

	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] END_POS = 6'd63;

	logic [1:0]            state_q;
	logic [5:0]            pos_q;
	logic [60:0]           cnt_q;
	logic [63:0]           len_q;
	logic [BLOCK_BITS-1:0] blk_q;

	logic        can_shift;
	logic        shift_en;
	logic [7:0]  shift_byte;
	logic        in_acc;
	logic [60:0] cnt_nxt;

	assign can_shift = !((pos_q == END_POS) && q_full);
	assign s_tready  = (state_q == F_ACC) && can_shift;
	assign in_acc    = s_tvalid && s_tready;
	assign cnt_nxt   = cnt_q + 61'(in_acc && s_tuser);

	always_comb begin
		shift_en   = 1'b0;
		shift_byte = 8'h00;
		unique case (state_q)
			F_ACC: begin
				shift_en   = in_acc && s_tuser;
				shift_byte = s_tdata;
			end
			F_PAD: begin
				shift_en   = can_shift;
				shift_byte = PAD_BYTE;
			end
			F_FILL: begin
				shift_en = can_shift && (pos_q != LEN_POS);
			end
			F_LEN: begin
				shift_en   = can_shift;
				shift_byte = len_q[63:56];
			end
			default: begin
				shift_en = 1'b0;
			end
		endcase
	end

	assign push                = shift_en && (pos_q == END_POS);
	assign push_item.final_blk = (state_q == F_LEN);
	assign push_item.blk       = {blk_q[BLOCK_BITS-9:0], shift_byte};

	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= {blk_q[BLOCK_BITS-9:0], shift_byte};
		end
		if (in_acc && s_tlast) begin
			len_q <= {cnt_nxt, 3'b000};
		end else if ((state_q == F_LEN) && shift_en) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_ACC;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (shift_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (push && push_item.final_blk) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_nxt;
			end
			unique case (state_q)
				F_ACC: begin
					if (in_acc && s_tlast) begin
						state_q <= F_PAD;
					end
				end
				F_PAD: begin
					if (shift_en) begin
						state_q <= F_FILL;
					end
				end
				F_FILL: begin
					if (pos_q == LEN_POS) begin
						state_q <= F_LEN;
					end
				end
				F_LEN: begin
					if (push) begin
						state_q <= F_ACC;
					end
				end
				default: begin
					state_q <= F_ACC;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/sha1md_queue.sv -----
// Two-entry block queue between the byte intake and the compression engine.
module sha1md_queue import sha1md_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  blk_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output blk_item_t head_item
);

	blk_item_t  ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_item  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("block pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && !head_valid))
		else $error("block popped from empty queue");

endmodule

// ----- hw/rtl/sha1md_back.sv -----
// Compression engine: 80-round unit, chaining state and digest word output.
module sha1md_back import sha1md_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  blk_item_t   head_item,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_RUN  = 2'd1;
	localparam logic [1:0] B_FIN  = 2'd2;

	logic [1:0]   state_q;
	logic [6:0]   rnd_q;
	logic         final_q;
	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  h_q [5];
	logic         out_busy_q;
	logic [2:0]   idx_q;
	logic [159:0] dig_q;

	logic [31:0]  w_mix;
	logic [31:0]  w_new;
	logic [31:0]  tmp;
	logic [31:0]  sum [5];
	logic         out_hs;
	logic         fin_go;

	assign pop    = (state_q == B_IDLE) && head_valid;
	assign w_mix  = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_new  = {w_mix[30:0], w_mix[31]};
	assign tmp    = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q
		+ round_k(rnd_q) + w_q[0];
	assign sum[0] = h_q[0] + a_q;
	assign sum[1] = h_q[1] + b_q;
	assign sum[2] = h_q[2] + c_q;
	assign sum[3] = h_q[3] + d_q;
	assign sum[4] = h_q[4] + e_q;
	assign out_hs = m_tvalid && m_tready;
	assign fin_go = (state_q == B_FIN) && !(final_q && out_busy_q);

	assign m_tvalid = out_busy_q;
	assign m_tdata  = dig_q[159:128];
	assign m_tuser  = idx_q;
	assign m_tlast  = (idx_q == LAST_WORD_IDX);

	always_ff @(posedge clk) begin
		if (pop) begin
			final_q <= head_item.final_blk;
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= head_item.blk[BLOCK_BITS-1-32*i -: 32];
			end
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == B_RUN) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (fin_go && final_q) begin
			dig_q <= {sum[0], sum[1], sum[2], sum[3], sum[4]};
		end else if (out_hs) begin
			dig_q <= {dig_q[127:0], 32'h0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			rnd_q      <= '0;
			out_busy_q <= 1'b0;
			idx_q      <= '0;
			h_q[0]     <= IV0;
			h_q[1]     <= IV1;
			h_q[2]     <= IV2;
			h_q[3]     <= IV3;
			h_q[4]     <= IV4;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= B_RUN;
						rnd_q   <= '0;
					end
				end
				B_RUN: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					if (fin_go) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (fin_go) begin
				if (final_q) begin
					h_q[0] <= IV0;
					h_q[1] <= IV1;
					h_q[2] <= IV2;
					h_q[3] <= IV3;
					h_q[4] <= IV4;
				end else begin
					for (int i = 0; i < 5; i++) begin
						h_q[i] <= sum[i];
					end
				end
			end
			if (fin_go && final_q) begin
				out_busy_q <= 1'b1;
				idx_q      <= '0;
			end else if (out_hs) begin
				idx_q <= idx_q + 3'd1;
				if (m_tlast) begin
					out_busy_q <= 1'b0;
				end
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (idx_q <= LAST_WORD_IDX))
		else $error("digest word index out of range");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RUN) |-> (rnd_q <= LAST_ROUND))
		else $error("round counter overran");
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_hs && m_tlast) |=> !m_tvalid)
		else $error("digest output still valid after final word");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == B_IDLE))
		else $error("block taken while engine busy");

endmodule

// ----- hw/rtl/sha1_message_digest_core.sv -----
// Top level of the SHA-1 message digest core.
// Usage:
//   Slave channel (s_*): one word per message byte. s_tdata holds the byte,
//   s_tuser flags that the byte is present, s_tlast ends the message. A word
//   with s_tlast and no byte ends the message without adding one.
//   Master channel (m_*): five digest words per message, most significant
//   first; m_tuser gives the word index 0..4, m_tlast marks index 4.
// Timing:
//   The intake takes one byte per cycle while s_tready is high and packs it
//   into the current block; s_tready is low while a message is padded and
//   while a full block waits for room in the two-entry queue. The round unit
//   works each block as load, 80 rounds and chaining add, and takes the next
//   block only after that add, so long messages stream at a rate set by the
//   single round unit. Ending a message adds the pad byte, the zero fill and
//   the eight length bytes, then one or two blocks go through the round unit;
//   each block still queued or running ahead delays the first digest word.
// Reset and stalls:
//   Reset empties the queue, restores the initial chaining value and clears
//   the byte count. A stalled receiver holds the digest in its output register;
//   the engine keeps compressing the next message and waits only to place
//   its digest, and the intake stalls when a full block meets a full queue.
module sha1_message_digest_core import sha1md_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast
);

	logic      push;
	blk_item_t push_item;
	logic      q_full;
	logic      pop;
	logic      head_valid;
	blk_item_t head_item;

	sha1md_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	sha1md_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	sha1md_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
